[rtl/cvfc_pkg.sv]
// shared widths for the chunk value frequency count block
package cvfc_pkg;

  localparam int unsigned VALUE_W = 14;
  localparam int unsigned OCC_W   = 7;

endpackage

[rtl/cvfc_store.sv]
// value store: one write port, one registered read port
module cvfc_store #(
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [cvfc_pkg::VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [cvfc_pkg::VALUE_W-1:0] rdata_o
);

  logic [cvfc_pkg::VALUE_W-1:0] mem_q [DEPTH];
  logic [cvfc_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/chunk_value_frequency_count_core.sv]
// Chunk value frequency count: loads a chunk, then reports each value and its count.
//
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. Each transaction writes value_i into the next free store position
// (one item per cycle); positions beyond DEPTH are dropped and flagged.
// The transaction with is_last_i set closes the chunk and raises busy.
// Output channel: one result per loaded position, in load order, each shown
// for exactly one cycle with valid_o high. The receiver cannot stall.
// Scan steps, set by the single read port of the value store: a position
// already marked as a duplicate goes through read, latch and emit; a first
// occurrence at position i of n adds one compare per later position between
// latch and emit.
// busy falls the cycle after the result with end_of_run_o; the chunk count
// and overflow flag are then clear for the next chunk.
// Reset clears the sequencer, count and flag. The duplicate marks sit in a
// small memory and each one is cleared as its position is loaded; the value
// store keeps junk, which is never read before being written.
module chunk_value_frequency_count_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [cvfc_pkg::VALUE_W-1:0] value_i,
  input  logic                         is_last_i,
  output logic                         valid_o,
  output logic [cvfc_pkg::VALUE_W-1:0] elem_value_o,
  output logic [cvfc_pkg::OCC_W-1:0]   occurrences_o,
  output logic                         overflow_o,
  output logic                         end_of_run_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_LATI = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [cvfc_pkg::VALUE_W-1:0] vi_q, vi_d;

  logic                         accept;
  logic                         st_we;
  logic [AW-1:0]                st_raddr;
  logic [cvfc_pkg::VALUE_W-1:0] st_rdata;

  logic          mark_mem_q [DEPTH];
  logic          mark_rdata_q;
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic          mark_wdata;

  cvfc_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(value_i),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign busy   = (state_q != S_LOAD);
  assign accept = start && !busy;
  assign st_we  = accept && (cnt_q < CW'(DEPTH));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    i_d        = i_q;
    j_d        = j_q;
    occ_d      = occ_q;
    vi_d       = vi_q;
    st_raddr   = i_q[AW-1:0];
    mark_we    = 1'b0;
    mark_waddr = cnt_q[AW-1:0];
    mark_wdata = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        // a freshly loaded position starts unmarked
        mark_we = st_we;
        if (accept) begin
          if (cnt_q < CW'(DEPTH)) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (is_last_i) begin
            i_d     = '0;
            state_d = S_RDI;
          end
        end
      end
      S_RDI: begin
        state_d = S_LATI;
      end
      S_LATI: begin
        vi_d = st_rdata;
        if (mark_rdata_q) begin
          occ_d   = '0;
          state_d = S_EMIT;
        end else if (i_q + CW'(1) == cnt_q) begin
          occ_d   = CW'(1);
          state_d = S_EMIT;
        end else begin
          occ_d    = CW'(1);
          j_d      = i_q + CW'(1);
          st_raddr = j_d[AW-1:0];
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        // store data here belongs to position j_q
        if (st_rdata == vi_q) begin
          occ_d      = occ_q + CW'(1);
          mark_we    = 1'b1;
          mark_waddr = j_q[AW-1:0];
          mark_wdata = 1'b1;
        end
        if (j_q + CW'(1) == cnt_q) begin
          state_d = S_EMIT;
        end else begin
          j_d      = j_q + CW'(1);
          st_raddr = j_d[AW-1:0];
        end
      end
      S_EMIT: begin
        if (i_q + CW'(1) == cnt_q) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = S_LOAD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_RDI;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vi_q <= vi_d;
  end

  // duplicate marks: read at position i_q, mark registered and ready in the next cycle
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem_q[mark_waddr] <= mark_wdata;
    end
    mark_rdata_q <= mark_mem_q[i_q[AW-1:0]];
  end

  assign valid_o       = (state_q == S_EMIT);
  assign elem_value_o  = vi_q;
  assign occurrences_o = cvfc_pkg::OCC_W'(occ_q);
  assign overflow_o    = drop_q;
  assign end_of_run_o  = valid_o && (i_q + CW'(1) == cnt_q);

  // results only appear while a chunk is being scanned
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe outside a scan");

  // closing transaction always starts a scan
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_last_i) |=> busy)
    else $error("closing transaction did not start a scan");

  // final result hands the block back for loading with a clean chunk
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_run_o |=> (!busy && cnt_q == '0 && !drop_q))
    else $error("chunk state not cleared after final result");

  // counts never exceed the number of loaded positions
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (occ_q <= cnt_q))
    else $error("count exceeds loaded positions");

endmodule
